@@ hw/rtl/utc_pkg.sv @@
// utc_pkg: shared types, constants and helper functions of the unicycle tracking core.
// No dependencies; utc_cordic_cell and the core import this package, as do the bench files.
package utc_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int MAX_STAGES        = 24;
  localparam int AW                = 34;

  typedef logic signed [AW-1:0] cw_t;
  typedef logic signed [31:0]   s32_t;

  localparam cw_t Q30_PI      = 34'sd3373259426;
  localparam cw_t Q30_TWO_PI  = 34'sd6746518852;
  localparam cw_t Q30_HALF_PI = 34'sd1686629713;
  localparam cw_t Q30_CLAMP   = 34'sd1602298227;
  localparam cw_t Q30_MARGIN  = 34'sd1073742;
  localparam cw_t Q30_K       = 34'sd652032874;

  localparam s32_t S32_MAX = 32'sh7fffffff;
  localparam s32_t S32_MIN = 32'sh80000000;

  localparam logic [1:0] REG_K1 = 2'd0;
  localparam logic [1:0] REG_K2 = 2'd1;
  localparam logic [1:0] REG_K3 = 2'd2;

  localparam cw_t ATAN [MAX_STAGES] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
    34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024, 34'sd512, 34'sd256,
    34'sd128
  };

  typedef struct packed {
    cw_t c;
    cw_t s;
  } cs_t;

  typedef struct packed {
    s32_t z1;
    s32_t z2;
    s32_t gv;
    s32_t gw;
    s32_t rv;
    s32_t rw;
    s32_t g;
    s32_t a1;
    s32_t b1;
    logic dpos;
    logic flip;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [30:0] c;
    logic        clamped;
    logic        neg;
  } d1p_t;

  typedef struct packed {
    s32_t        ang;
    logic [30:0] c;
    logic        clamped;
    logic        neg;
    logic        ovf;
  } d2p_t;

  // elaboration-time rotation, same steps as the cell row
  function automatic cs_t cordic_cs(input cw_t ang, input int stages);
    cw_t x;
    cw_t y;
    cw_t z;
    cw_t xs;
    cw_t ys;
    cs_t r;
    x = Q30_K;
    y = '0;
    z = ang;
    for (int i = 0; i < MAX_STAGES; i++) begin
      if (i < stages) begin
        xs = x >>> i;
        ys = y >>> i;
        if (!z[AW-1]) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN[i];
        end
      end
    end
    r.c = x;
    r.s = y;
    return r;
  endfunction

  function automatic s32_t sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      return S32_MAX;
    end else if (v < -72'sd2147483648) begin
      return S32_MIN;
    end
    return s32_t'(v[31:0]);
  endfunction

  function automatic logic signed [32:0] abs33(input s32_t v);
    logic signed [32:0] e;
    e = 33'(v);
    return e[32] ? -e : e;
  endfunction

endpackage

@@ hw/rtl/utc_if.sv @@
// utc_if: valid/ready channels of the unicycle tracking core (sample, command, config).
// No dependencies.
interface utc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic signed [15:0] robot_heading;
  logic signed [31:0] robot_lin_vel;
  logic signed [31:0] robot_ang_vel;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [15:0] ref_heading;
  logic signed [31:0] ref_lin_vel;
  logic signed [31:0] ref_ang_vel;
  modport source (output valid, robot_x, robot_y, robot_heading, robot_lin_vel,
                  robot_ang_vel, ref_x, ref_y, ref_heading, ref_lin_vel, ref_ang_vel,
                  input ready);
  modport sink (input valid, robot_x, robot_y, robot_heading, robot_lin_vel,
                robot_ang_vel, ref_x, ref_y, ref_heading, ref_lin_vel, ref_ang_vel,
                output ready);
endinterface

interface utc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cmd_lin_vel;
  logic signed [31:0] cmd_ang_vel;
  logic               heading_clamped;
  modport source (output valid, cmd_lin_vel, cmd_ang_vel, heading_clamped, input ready);
  modport sink (input valid, cmd_lin_vel, cmd_ang_vel, heading_clamped, output ready);
endinterface

interface utc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [15:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ hw/rtl/utc_cordic_cell.sv @@
// utc_cordic_cell: one rotation step of the sin/cos cell row, registered.
// Depends on utc_pkg (word type, arctangent table).
module utc_cordic_cell import utc_pkg::*; #(
  parameter int  IDX   = 0,
  parameter type pay_t = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  cw_t  x_i,
  input  cw_t  y_i,
  input  cw_t  z_i,
  input  pay_t pay_i,
  output logic vld_o,
  output cw_t  x_o,
  output cw_t  y_o,
  output cw_t  z_o,
  output pay_t pay_o
);

  logic vld_r;
  cw_t  x_r, y_r, z_r;
  pay_t pay_r;
  cw_t  xs, ys, x_nxt, y_nxt, z_nxt;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (!z_i[AW-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN[IDX];
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      pay_r <= pay_i;
    end
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign pay_o = pay_r;

endmodule

@@ hw/rtl/utc_div_cell.sv @@
// utc_div_cell: one quotient bit of a restoring divider row, registered.
// No package dependencies; divisor is shifted by the cell's fixed weight K.
module utc_div_cell #(
  parameter int  W     = 64,
  parameter int  DW    = 31,
  parameter int  QW    = 33,
  parameter int  K     = 0,
  parameter type pay_t = logic
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [W-1:0]  rem_i,
  input  logic [QW-1:0] q_i,
  input  logic [DW-1:0] d_i,
  input  pay_t          pay_i,
  output logic          vld_o,
  output logic [W-1:0]  rem_o,
  output logic [QW-1:0] q_o,
  output pay_t          pay_o
);

  logic          vld_r;
  logic [W-1:0]  rem_r, rem_nxt, dsh;
  logic [QW-1:0] q_r, q_nxt;
  pay_t          pay_r;
  logic          ge;

  always_comb begin
    dsh     = W'(d_i) << K;
    ge      = rem_i >= dsh;
    rem_nxt = ge ? rem_i - dsh : rem_i;
    q_nxt   = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      pay_r <= pay_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign pay_o = pay_r;

endmodule

@@ hw/rtl/unicycle_tracking_control_law_core.sv @@
// unicycle_tracking_control_law_core: pipelined unicycle tracking law (cells for sin/cos,
// tangent and final division). Depends on utc_pkg, utc_if, utc_cordic_cell, utc_div_cell.
//
//   channel  dir  word                                     handshake
//   in_ch    in   robot pose/velocities, reference, ff vel valid/ready
//   out_ch   out  cmd_lin_vel, cmd_ang_vel, heading_clamped valid/ready
//   cfg_ch   in   idx (0..2 gains), 16-bit Q8.8 data       valid/ready, always ready
//
// One word per cycle in, one per cycle out while the output is not stalled. The row runs
// through the rotation cells, 27 tangent divider cells, 33 command divider cells and the
// multiply stages. A stalled output holds the whole row; in_ch.ready follows it.
// Synchronous reset clears the valid bits and loads all gains with 1.0.
module unicycle_tracking_control_law_core import utc_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic      clk,
  input  logic      rst_n,
  utc_cfg_if.sink   cfg_ch,
  utc_in_if.sink    in_ch,
  utc_out_if.source out_ch
);

  localparam int NCS    = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int CDW    = 31;
  localparam int Q1W    = 27;
  localparam int Q2W    = 33;
  localparam int DIV1_W = 58;
  localparam int DIV2_W = 64;
  localparam cs_t CLP_P = cordic_cs(Q30_CLAMP, NCS);
  localparam cs_t CLP_N = cordic_cs(-Q30_CLAMP, NCS);
  localparam logic [Q2W-1:0] Q2_LIM = Q2W'(64'h8000_0000);

  logic adv;
  logic [15:0] k1_r, k2_r, k3_r;

  // config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= 16'd256;
      k2_r <= 16'd256;
      k3_r <= 16'd256;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_K1:  k1_r <= cfg_ch.data;
        REG_K2:  k2_r <= cfg_ch.data;
        REG_K3:  k3_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic out_vld_r;
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: errors
  logic  v1_r;
  side_t s1_r;
  cw_t   d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.z1   <= sat32(72'(in_ch.robot_x) - 72'(in_ch.ref_x));
      s1_r.z2   <= sat32(72'(in_ch.robot_y) - 72'(in_ch.ref_y));
      s1_r.gv   <= in_ch.ref_lin_vel;
      s1_r.gw   <= in_ch.ref_ang_vel;
      s1_r.rv   <= in_ch.robot_lin_vel;
      s1_r.rw   <= in_ch.robot_ang_vel;
      s1_r.g    <= '0;
      s1_r.a1   <= '0;
      s1_r.b1   <= '0;
      s1_r.dpos <= 1'b0;
      s1_r.flip <= 1'b0;
      d1_r      <= (AW'(in_ch.robot_heading) - AW'(in_ch.ref_heading)) <<< 17;
    end
  end

  // stage 2: angle fold, gain products
  logic               v2_r;
  side_t              s2_r;
  side_t              s2_nxt;
  cw_t                h2_r;
  cw_t                fa, fh;
  logic               ff;
  logic signed [49:0] gp, bp;
  logic signed [48:0] ap;

  always_comb begin
    fa = d1_r;
    if (d1_r > Q30_PI) begin
      fa = d1_r - Q30_TWO_PI;
    end else if (d1_r < -Q30_PI) begin
      fa = d1_r + Q30_TWO_PI;
    end
    fh = fa;
    ff = 1'b0;
    if (fa > Q30_HALF_PI) begin
      fh = fa - Q30_PI;
      ff = 1'b1;
    end else if (fa < -Q30_HALF_PI) begin
      fh = fa + Q30_PI;
      ff = 1'b1;
    end
    gp = 50'($signed({1'b0, k1_r})) * 50'(abs33(s1_r.gv));
    ap = 49'($signed({1'b0, k2_r})) * 49'(s1_r.rw);
    bp = 50'($signed({1'b0, k3_r})) * 50'(abs33(s1_r.rv));
    s2_nxt      = s1_r;
    s2_nxt.g    = sat32(72'(gp >>> 8));
    s2_nxt.a1   = sat32(72'(ap >>> 8));
    s2_nxt.b1   = sat32(72'(bp >>> 8));
    s2_nxt.dpos = d1_r > 0;
    s2_nxt.flip = ff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
      h2_r <= fh;
    end
  end

  // rotation cells
  logic  cv [0:NCS];
  cw_t   cx [0:NCS];
  cw_t   cy [0:NCS];
  cw_t   cz [0:NCS];
  side_t cp [0:NCS];

  assign cv[0] = v2_r;
  assign cx[0] = Q30_K;
  assign cy[0] = '0;
  assign cz[0] = h2_r;
  assign cp[0] = s2_r;

  genvar i;
  generate
    for (i = 0; i < NCS; i++) begin : g_rot
      utc_cordic_cell #(.IDX(i), .pay_t(side_t)) u_cell (
        .clk, .rst_n, .en(adv),
        .vld_i(cv[i]), .x_i(cx[i]), .y_i(cy[i]), .z_i(cz[i]), .pay_i(cp[i]),
        .vld_o(cv[i+1]), .x_o(cx[i+1]), .y_o(cy[i+1]), .z_o(cz[i+1]), .pay_o(cp[i+1])
      );
    end
  endgenerate

  // stage 3: unfold, clamp, tangent divider setup
  logic              v3_r;
  d1p_t              p3_r;
  logic [DIV1_W-1:0] r3_r;
  cw_t               fc, fs, sc, ss, sa;
  logic              cl;

  always_comb begin
    fc = cp[NCS].flip ? -cx[NCS] : cx[NCS];
    fs = cp[NCS].flip ? -cy[NCS] : cy[NCS];
    sc = fc;
    ss = fs;
    cl = 1'b0;
    if (fc < Q30_MARGIN) begin
      sc = cp[NCS].dpos ? CLP_P.c : CLP_N.c;
      ss = cp[NCS].dpos ? CLP_P.s : CLP_N.s;
      cl = 1'b1;
    end
    sa = ss[AW-1] ? -ss : ss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= cv[NCS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r.sd      <= cp[NCS];
      p3_r.c       <= sc[CDW-1:0];
      p3_r.clamped <= cl;
      p3_r.neg     <= ss[AW-1];
      r3_r         <= DIV1_W'(sa) << 16;
    end
  end

  // tangent divider cells
  logic              dv1 [0:Q1W];
  logic [DIV1_W-1:0] dr1 [0:Q1W];
  logic [Q1W-1:0]    dq1 [0:Q1W];
  d1p_t              dp1 [0:Q1W];

  assign dv1[0] = v3_r;
  assign dr1[0] = r3_r;
  assign dq1[0] = '0;
  assign dp1[0] = p3_r;

  genvar j;
  generate
    for (j = 0; j < Q1W; j++) begin : g_div1
      utc_div_cell #(.W(DIV1_W), .DW(CDW), .QW(Q1W), .K(Q1W-1-j), .pay_t(d1p_t)) u_cell (
        .clk, .rst_n, .en(adv),
        .vld_i(dv1[j]), .rem_i(dr1[j]), .q_i(dq1[j]), .d_i(dp1[j].c), .pay_i(dp1[j]),
        .vld_o(dv1[j+1]), .rem_o(dr1[j+1]), .q_o(dq1[j+1]), .pay_o(dp1[j+1])
      );
    end
  endgenerate

  // M1: products with tangent
  logic               vm1_r;
  d1p_t               pm1_r;
  s32_t               p_r, a2_r, b2_r;
  logic [31:0]        c2_r;
  s32_t               z3;
  logic signed [63:0] pz, pa, pb;
  logic [61:0]        cc;

  always_comb begin
    z3 = dp1[Q1W].neg ? -s32_t'(32'(dq1[Q1W])) : s32_t'(32'(dq1[Q1W]));
    pz = 64'(dp1[Q1W].sd.z2) * 64'(z3);
    pa = 64'(dp1[Q1W].sd.a1) * 64'(dp1[Q1W].sd.z2);
    pb = 64'(dp1[Q1W].sd.b1) * 64'(z3);
    cc = 62'(dp1[Q1W].c) * 62'(dp1[Q1W].c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else if (adv) begin
      vm1_r <= dv1[Q1W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm1_r <= dp1[Q1W];
      p_r   <= sat32(72'(pz >>> 16));
      a2_r  <= sat32(72'(pa >>> 16));
      b2_r  <= sat32(72'(pb >>> 16));
      c2_r  <= cc[61:30];
    end
  end

  // M2: sums
  logic        vm2_r;
  d1p_t        pm2_r;
  s32_t        e_r, br_r;
  logic [31:0] c2m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else if (adv) begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm2_r <= pm1_r;
      e_r   <= sat32(72'(pm1_r.sd.z1) + 72'(p_r));
      br_r  <= sat32(-72'(a2_r) - 72'(b2_r));
      c2m_r <= c2_r;
    end
  end

  // M3: second products
  logic               vm3_r;
  d1p_t               pm3_r;
  s32_t               t_r;
  logic signed [34:0] m_r;
  logic signed [63:0] tp;
  logic signed [64:0] mp;

  always_comb begin
    tp = 64'(pm2_r.sd.g) * 64'(e_r);
    mp = 65'(br_r) * 65'($signed({1'b0, c2m_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm3_r <= 1'b0;
    end else if (adv) begin
      vm3_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm3_r <= pm2_r;
      t_r   <= sat32(72'(tp >>> 16));
      m_r   <= 35'(mp >>> 30);
    end
  end

  // M4: numerator, angular command, command divider setup
  logic               v4_r;
  d2p_t               p4_r;
  logic [DIV2_W-1:0]  r4_r;
  logic signed [33:0] num, mag;
  logic [DIV2_W-1:0]  nw;
  logic               ovf;

  always_comb begin
    num = 34'(pm3_r.sd.gv) - 34'(t_r);
    mag = num[33] ? -num : num;
    nw  = DIV2_W'(mag) << 30;
    ovf = nw >= (DIV2_W'(pm3_r.c) << Q2W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= vm3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r.ang     <= sat32(72'(m_r) + 72'(pm3_r.sd.gw));
      p4_r.c       <= pm3_r.c;
      p4_r.clamped <= pm3_r.clamped;
      p4_r.neg     <= num[33];
      p4_r.ovf     <= ovf;
      r4_r         <= nw;
    end
  end

  // command divider cells
  logic              dv2 [0:Q2W];
  logic [DIV2_W-1:0] dr2 [0:Q2W];
  logic [Q2W-1:0]    dq2 [0:Q2W];
  d2p_t              dp2 [0:Q2W];

  assign dv2[0] = v4_r;
  assign dr2[0] = r4_r;
  assign dq2[0] = '0;
  assign dp2[0] = p4_r;

  genvar k;
  generate
    for (k = 0; k < Q2W; k++) begin : g_div2
      utc_div_cell #(.W(DIV2_W), .DW(CDW), .QW(Q2W), .K(Q2W-1-k), .pay_t(d2p_t)) u_cell (
        .clk, .rst_n, .en(adv),
        .vld_i(dv2[k]), .rem_i(dr2[k]), .q_i(dq2[k]), .d_i(dp2[k].c), .pay_i(dp2[k]),
        .vld_o(dv2[k+1]), .rem_o(dr2[k+1]), .q_o(dq2[k+1]), .pay_o(dp2[k+1])
      );
    end
  endgenerate

  // output register
  s32_t lin_r, ang_r, lin;
  logic cl_r;
  logic [Q2W-1:0] qf;

  always_comb begin
    qf = dq2[Q2W];
    if (dp2[Q2W].ovf) begin
      lin = dp2[Q2W].neg ? S32_MIN : S32_MAX;
    end else if (!dp2[Q2W].neg) begin
      lin = (qf[Q2W-1] || qf[31]) ? S32_MAX : s32_t'(qf[31:0]);
    end else begin
      lin = (qf > Q2_LIM) ? S32_MIN : -s32_t'(qf[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv2[Q2W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_r <= lin;
      ang_r <= dp2[Q2W].ang;
      cl_r  <= dp2[Q2W].clamped;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.cmd_lin_vel     = lin_r;
  assign out_ch.cmd_ang_vel     = ang_r;
  assign out_ch.heading_clamped = cl_r;

endmodule

@@ dv/unicycle_tracking_control_law_core_chk.sv @@
// Checker for the unicycle tracking core: watches the config, sample and command channels,
// predicts each command word from the sample word and the gains, and compares in order.
// Depends on utc_pkg and utc_if.
`timescale 1ns / 100ps
module unicycle_tracking_control_law_core_chk import utc_pkg::*; #(
  parameter int STAGES = DEF_CORDIC_STAGES
) (
  input  logic clk,
  input  logic rst_n,
  utc_cfg_if   cfg_ch,
  utc_in_if    in_ch,
  utc_out_if   out_ch,
  output int   pending,
  output int   fails
);

  typedef struct {
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic               clamped;
  } cmd_t;

  localparam longint ONE30 = 64'sd1073741824;

  longint atan_tab [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128
  };

  logic [15:0] k_lon, k_lat, k_hdg;
  cmd_t        cmd_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic rotate(input longint a, output longint c, output longint s);
    longint x, y, z, xs, ys;
    x = 652032874;
    y = 0;
    z = a;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endtask

  task automatic predict_command(output cmd_t r);
    longint z1, z2, z3, d, a, c, s, p, e, g, t, num, a1, a2, b1, b2, br, c2, m;
    longint gv, gw, rv, rw;
    logic   flip;
    gv = longint'(in_ch.ref_lin_vel);
    gw = longint'(in_ch.ref_ang_vel);
    rv = longint'(in_ch.robot_lin_vel);
    rw = longint'(in_ch.robot_ang_vel);
    z1 = clip32(longint'(in_ch.robot_x) - longint'(in_ch.ref_x));
    z2 = clip32(longint'(in_ch.robot_y) - longint'(in_ch.ref_y));
    d = (longint'(in_ch.robot_heading) - longint'(in_ch.ref_heading)) * 131072;
    a = d;
    flip = 1'b0;
    while (a > longint'(Q30_PI)) a -= longint'(Q30_TWO_PI);
    while (a < -longint'(Q30_PI)) a += longint'(Q30_TWO_PI);
    if (a > longint'(Q30_HALF_PI)) begin
      a -= longint'(Q30_PI); flip = 1'b1;
    end else if (a < -longint'(Q30_HALF_PI)) begin
      a += longint'(Q30_PI); flip = 1'b1;
    end
    rotate(a, c, s);
    if (flip) begin
      c = -c; s = -s;
    end
    r.clamped = 1'b0;
    if (c < longint'(Q30_MARGIN)) begin
      rotate(d > 0 ? longint'(Q30_CLAMP) : -longint'(Q30_CLAMP), c, s);
      r.clamped = 1'b1;
    end
    z3 = (s * 65536) / c;
    p = clip32((z2 * z3) >>> 16);
    e = clip32(z1 + p);
    g = clip32((longint'(k_lon) * mag(gv)) >>> 8);
    t = clip32((g * e) >>> 16);
    num = gv - t;
    r.lin = 32'(clip32((num * ONE30) / c));
    a1 = clip32((longint'(k_lat) * rw) >>> 8);
    a2 = clip32((a1 * z2) >>> 16);
    b1 = clip32((longint'(k_hdg) * mag(rv)) >>> 8);
    b2 = clip32((b1 * z3) >>> 16);
    br = clip32(-a2 - b2);
    c2 = (c * c) >>> 30;
    m = (br * c2) >>> 30;
    r.ang = 32'(clip32(m + gw));
  endtask

  assign pending = cmd_q.size();

  always @(posedge clk) begin
    cmd_t want;
    if (!rst_n) begin
      k_lon <= 16'd256;
      k_lat <= 16'd256;
      k_hdg <= 16'd256;
      fails = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.idx)
          REG_K1: k_lon <= cfg_ch.data;
          REG_K2: k_lat <= cfg_ch.data;
          REG_K3: k_hdg <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_command(want);
        cmd_q = {cmd_q, want};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (cmd_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected command word lin=%0d ang=%0d",
                                    out_ch.cmd_lin_vel, out_ch.cmd_ang_vel);
        end else begin
          want = cmd_q.pop_front();
          if (want.lin !== out_ch.cmd_lin_vel || want.ang !== out_ch.cmd_ang_vel ||
              want.clamped !== out_ch.heading_clamped) begin
            fails++;
            if (fails <= 10)
              $display("cmd mismatch: exp lin=%0d ang=%0d clamp=%0b got lin=%0d ang=%0d clamp=%0b",
                       want.lin, want.ang, want.clamped, out_ch.cmd_lin_vel,
                       out_ch.cmd_ang_vel, out_ch.heading_clamped);
          end
        end
      end
    end
  end

endmodule

@@ dv/unicycle_tracking_control_law_core_tb.sv @@
// Top of the unicycle tracking core bench: clock, reset, sample and config stimulus with
// random gaps, random command stalls and the verdict. Depends on utc_pkg, utc_if, the checker.
`timescale 1ns / 100ps
module unicycle_tracking_control_law_core_tb import utc_pkg::*;;

  localparam int LAT   = DEF_CORDIC_STAGES + 68;
  localparam int LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   pending, fails, cycles;
  logic done = 1'b0;

  utc_cfg_if cfg_ch ();
  utc_in_if  in_ch ();
  utc_out_if out_ch ();

  unicycle_tracking_control_law_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .in_ch(in_ch), .out_ch(out_ch)
  );

  unicycle_tracking_control_law_core_chk chk (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .in_ch(in_ch), .out_ch(out_ch),
    .pending(pending), .fails(fails)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("unicycle_tracking_control_law_core: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 4))
      0: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      1: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_hdg(logic [15:0] base);
    case ($urandom_range(0, 3))
      0: return base + 16'($signed($urandom_range(0, 2000)) - 1000);
      1: return base + ($urandom_range(0, 1) ? 16'd12868 : -16'd12868)
                + 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [31:0] rx, ry, logic [15:0] rh, logic [31:0] rv, rw,
                           logic [31:0] gx, gy, logic [15:0] gh, logic [31:0] gv, gw);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.robot_x <= rx; in_ch.robot_y <= ry; in_ch.robot_heading <= rh;
    in_ch.robot_lin_vel <= rv; in_ch.robot_ang_vel <= rw;
    in_ch.ref_x <= gx; in_ch.ref_y <= gy; in_ch.ref_heading <= gh;
    in_ch.ref_lin_vel <= gv; in_ch.ref_ang_vel <= gw;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] gh;
    gh = 16'($urandom);
    send_word(pick_q16(), pick_q16(), pick_hdg(gh), pick_q16(), pick_q16(),
              pick_q16(), pick_q16(), gh, pick_q16(), pick_q16());
  endtask

  task automatic write_gain(logic [1:0] idx, logic [15:0] val);
    cfg_ch.idx <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic set_gains(logic [15:0] k1, k2, k3);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
    write_gain(REG_K1, k1);
    write_gain(REG_K2, k2);
    write_gain(REG_K3, k3);
    cfg_ch.valid <= 1'b0;
  endtask

  // command side stalls
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    cfg_ch.valid = 1'b0; cfg_ch.idx = '0; cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.robot_x = '0; in_ch.robot_y = '0; in_ch.robot_heading = '0;
    in_ch.robot_lin_vel = '0; in_ch.robot_ang_vel = '0;
    in_ch.ref_x = '0; in_ch.ref_y = '0; in_ch.ref_heading = '0;
    in_ch.ref_lin_vel = '0; in_ch.ref_ang_vel = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words at reset gains
    send_word('0, '0, 16'd0, '0, '0, '0, '0, 16'd0, '0, '0);
    send_word(mx, mx, 16'h7fff, mx, mx, mn, mn, 16'h8000, mx, mx);
    send_word(mn, mn, 16'h8000, mn, mn, mx, mx, 16'h7fff, mn, mn);
    send_word(mx, mn, 16'h7fff, mn, mx, mx, mn, 16'h7fff, mn, mx);
    send_word(32'h10000, 32'h20000, 16'd12868, 32'h10000, 32'h10000,
              '0, '0, 16'd0, 32'h10000, 32'h8000);
    send_word(32'h10000, 32'h20000, -16'd12868, 32'h10000, 32'h10000,
              '0, '0, 16'd0, 32'h10000, 32'h8000);
    send_word(32'h10000, 32'hfffe0000, 16'd12860, 32'h20000, 32'hffff0000,
              '0, '0, 16'd0, 32'hfffe0000, '0);
    send_word(32'h10000, 32'h10000, 16'd25736, 32'h10000, 32'h10000,
              '0, '0, 16'd0, 32'h10000, 32'h10000);
    send_word(32'h10000, 32'h10000, 16'd25736, 32'h10000, 32'h10000,
              '0, '0, -16'd12868, 32'h10000, 32'h10000);
    send_word(32'h30000, 32'hfffd0000, 16'd4000, 32'h18000, 32'h4000,
              32'h10000, 32'h10000, 16'd3000, 32'hffff0000, 32'h1000);
    send_word(32'hffffffff, 32'h1, 16'd1, 32'hffffffff, 32'h1,
              32'h1, 32'hffffffff, 16'hffff, 32'h1, 32'hffffffff);
    send_word(32'h55555555, 32'haaaaaaaa, 16'h5555, 32'haaaaaaaa, 32'h55555555,
              32'haaaaaaaa, 32'h55555555, 16'haaaa, 32'h55555555, 32'haaaaaaaa);
    repeat (150) send_random();

    set_gains(16'd0, 16'd0, 16'd0);
    repeat (150) send_random();
    set_gains(16'hffff, 16'hffff, 16'hffff);
    repeat (150) send_random();
    set_gains(16'd128, 16'd1024, 16'd64);
    repeat (150) send_random();
    set_gains(16'($urandom), 16'($urandom), 16'($urandom));
    repeat (200) send_random();

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
    if (fails == 0) begin
      $display("unicycle_tracking_control_law_core: match");
    end else begin
      $display("unicycle_tracking_control_law_core: mismatch");
    end
    $finish;
  end

endmodule

@@ unicycle_tracking_control_law_core.f @@
hw/rtl/utc_pkg.sv
hw/rtl/utc_if.sv
hw/rtl/utc_cordic_cell.sv
hw/rtl/utc_div_cell.sv
hw/rtl/unicycle_tracking_control_law_core.sv
dv/unicycle_tracking_control_law_core_chk.sv
dv/unicycle_tracking_control_law_core_tb.sv
